>>> src/tbpe_pkg.sv
// shared types and constants of the tape block pulse encoder
package tbpe_pkg;

	localparam int unsigned RUN_SLOTS = 12;

	localparam logic [3:0] SLOT_PILOT    = 4'd0;
	localparam logic [3:0] SLOT_SYNC_ONE = 4'd1;
	localparam logic [3:0] SLOT_SYNC_TWO = 4'd2;
	localparam logic [3:0] SLOT_BIT0     = 4'd3;
	localparam logic [3:0] SLOT_PAUSE    = 4'd11;

	localparam logic [2:0] REG_PILOT_LENGTH    = 3'd0;
	localparam logic [2:0] REG_PILOT_COUNT     = 3'd1;
	localparam logic [2:0] REG_SYNC_ONE_LENGTH = 3'd2;
	localparam logic [2:0] REG_SYNC_TWO_LENGTH = 3'd3;
	localparam logic [2:0] REG_ZERO_BIT_LENGTH = 3'd4;
	localparam logic [2:0] REG_ONE_BIT_LENGTH  = 3'd5;
	localparam logic [2:0] REG_PAUSE_MS        = 3'd6;
	localparam logic [2:0] REG_AUTO_PILOT      = 3'd7;

	localparam logic [15:0] RST_PILOT_LENGTH    = 16'd2168;
	localparam logic [15:0] RST_PILOT_COUNT     = 16'd3223;
	localparam logic [15:0] RST_SYNC_ONE_LENGTH = 16'd667;
	localparam logic [15:0] RST_SYNC_TWO_LENGTH = 16'd735;
	localparam logic [15:0] RST_ZERO_BIT_LENGTH = 16'd855;
	localparam logic [15:0] RST_ONE_BIT_LENGTH  = 16'd1710;
	localparam logic [15:0] RST_PAUSE_MS        = 16'd1000;

	localparam logic [11:0] TSTATES_PER_MS    = 12'd3500;
	localparam logic [15:0] AUTO_PILOT_HEADER = 16'd8063;
	localparam logic [15:0] AUTO_PILOT_DATA   = 16'd3223;
	localparam logic [3:0]  MAX_BITS          = 4'd8;

	typedef enum logic [2:0] {
		KIND_PILOT    = 3'd0,
		KIND_SYNC_ONE = 3'd1,
		KIND_SYNC_TWO = 3'd2,
		KIND_ZERO_BIT = 3'd3,
		KIND_ONE_BIT  = 3'd4,
		KIND_PAUSE    = 3'd5
	} run_kind_t;

	typedef struct packed {
		logic [15:0] pilot_length;
		logic [15:0] pilot_count;
		logic [15:0] sync_one_length;
		logic [15:0] sync_two_length;
		logic [15:0] zero_bit_length;
		logic [15:0] one_bit_length;
		logic [15:0] pause_len_ms;
		logic [27:0] pause_duration;
		logic        auto_pilot;
	} tbpe_cfg_t;

	typedef struct packed {
		logic [RUN_SLOTS-1:0] run_mask;
		logic [15:0]          pilot_count;
		logic [7:0]           data_byte;
	} tbpe_entry_t;

endpackage

>>> src/tbpe_cfg.sv
// configuration register file with precomputed pause duration
module tbpe_cfg
	import tbpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output tbpe_cfg_t   cfg
);

	tbpe_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pilot_length    <= RST_PILOT_LENGTH;
			cfg_q.pilot_count     <= RST_PILOT_COUNT;
			cfg_q.sync_one_length <= RST_SYNC_ONE_LENGTH;
			cfg_q.sync_two_length <= RST_SYNC_TWO_LENGTH;
			cfg_q.zero_bit_length <= RST_ZERO_BIT_LENGTH;
			cfg_q.one_bit_length  <= RST_ONE_BIT_LENGTH;
			cfg_q.pause_len_ms    <= RST_PAUSE_MS;
			cfg_q.pause_duration  <= 28'(RST_PAUSE_MS) * 28'(TSTATES_PER_MS);
			cfg_q.auto_pilot      <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PILOT_LENGTH:    cfg_q.pilot_length    <= cfg_data;
				REG_PILOT_COUNT:     cfg_q.pilot_count     <= cfg_data;
				REG_SYNC_ONE_LENGTH: cfg_q.sync_one_length <= cfg_data;
				REG_SYNC_TWO_LENGTH: cfg_q.sync_two_length <= cfg_data;
				REG_ZERO_BIT_LENGTH: cfg_q.zero_bit_length <= cfg_data;
				REG_ONE_BIT_LENGTH:  cfg_q.one_bit_length  <= cfg_data;
				REG_PAUSE_MS: begin
					cfg_q.pause_len_ms   <= cfg_data;
					cfg_q.pause_duration <= 28'(cfg_data) * 28'(TSTATES_PER_MS);
				end
				REG_AUTO_PILOT:      cfg_q.auto_pilot      <= cfg_data[0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> src/tbpe_front.sv
// front end: accepts bytes and works out which runs each one causes
module tbpe_front
	import tbpe_pkg::*;
(
	input  tbpe_cfg_t   cfg,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_of_block,
	input  logic        last_of_block,
	input  logic [3:0]  bit_count,
	input  logic        empty_block,
	input  logic        queue_full,
	output logic        push,
	output tbpe_entry_t push_entry
);

	logic [3:0]  nbits;
	logic [15:0] pilot_pulses;

	always_comb begin
		if (empty_block) begin
			nbits = 4'd0;
		end else if (bit_count > MAX_BITS) begin
			nbits = MAX_BITS;
		end else begin
			nbits = bit_count;
		end

		if (cfg.auto_pilot) begin
			pilot_pulses = (!empty_block && !data_byte[7]) ? AUTO_PILOT_HEADER : AUTO_PILOT_DATA;
		end else begin
			pilot_pulses = cfg.pilot_count;
		end

		push_entry.run_mask = '0;
		push_entry.run_mask[SLOT_PILOT]    = first_of_block && (pilot_pulses != 16'd0);
		push_entry.run_mask[SLOT_SYNC_ONE] = first_of_block && (cfg.sync_one_length != 16'd0);
		push_entry.run_mask[SLOT_SYNC_TWO] = first_of_block && (cfg.sync_two_length != 16'd0);
		for (int b = 0; b < 8; b++) begin
			push_entry.run_mask[int'(SLOT_BIT0) + b] = (4'(b) < nbits);
		end
		push_entry.run_mask[SLOT_PAUSE] = last_of_block && (cfg.pause_len_ms != 16'd0);
		push_entry.pilot_count = pilot_pulses;
		push_entry.data_byte   = data_byte;
	end

	// words with no run are taken and dropped
	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full && (push_entry.run_mask != '0);

endmodule

>>> src/tbpe_fifo.sv
// short queue of classified words between front and back
module tbpe_fifo
	import tbpe_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tbpe_entry_t push_entry,
	output logic        full,
	output logic        head_valid,
	output tbpe_entry_t head_entry,
	input  logic        pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tbpe_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/tbpe_back.sv
// back end: walks each run mask, sends one run a cycle unless stalled
module tbpe_back
	import tbpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  tbpe_cfg_t   cfg,
	input  logic        head_valid,
	input  tbpe_entry_t head_entry,
	output logic        pop,
	output logic        run_valid,
	input  logic        run_stall,
	output logic [27:0] duration,
	output logic [15:0] repeat_count,
	output logic [2:0]  run_kind,
	output logic        last_run
);

	logic                 cur_valid_q;
	logic [RUN_SLOTS-1:0] cur_mask_q;
	logic [15:0]          cur_pilot_q;
	logic [7:0]           cur_data_q;

	logic                 run_valid_q;
	logic [27:0]          duration_q;
	logic [15:0]          repeat_count_q;
	run_kind_t            run_kind_q;
	logic                 last_run_q;

	logic                 out_free;
	logic [3:0]           slot;
	logic [RUN_SLOTS-1:0] remaining;
	logic [3:0]           bit_sel;
	logic                 data_bit;
	logic [27:0]          nxt_duration;
	logic [15:0]          nxt_repeat;
	run_kind_t            nxt_kind;

	always_comb begin
		slot = '0;
		for (int i = RUN_SLOTS - 1; i >= 0; i--) begin
			if (cur_mask_q[i]) begin
				slot = 4'(i);
			end
		end
		remaining = cur_mask_q & ~(RUN_SLOTS'(1) << slot);
		bit_sel   = slot - SLOT_BIT0;
		data_bit  = cur_data_q[3'd7 - bit_sel[2:0]];

		unique case (slot)
			SLOT_PILOT: begin
				nxt_duration = 28'(cfg.pilot_length);
				nxt_repeat   = cur_pilot_q;
				nxt_kind     = KIND_PILOT;
			end
			SLOT_SYNC_ONE: begin
				nxt_duration = 28'(cfg.sync_one_length);
				nxt_repeat   = 16'd1;
				nxt_kind     = KIND_SYNC_ONE;
			end
			SLOT_SYNC_TWO: begin
				nxt_duration = 28'(cfg.sync_two_length);
				nxt_repeat   = 16'd1;
				nxt_kind     = KIND_SYNC_TWO;
			end
			SLOT_PAUSE: begin
				nxt_duration = cfg.pause_duration;
				nxt_repeat   = 16'd1;
				nxt_kind     = KIND_PAUSE;
			end
			default: begin
				nxt_duration = 28'(data_bit ? cfg.one_bit_length : cfg.zero_bit_length);
				nxt_repeat   = 16'd2;
				nxt_kind     = data_bit ? KIND_ONE_BIT : KIND_ZERO_BIT;
			end
		endcase
	end

	assign out_free = !run_valid_q || !run_stall;
	assign pop      = head_valid && (!cur_valid_q || (out_free && (remaining == '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_mask_q  <= '0;
			run_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				run_valid_q <= cur_valid_q;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
				cur_mask_q  <= head_entry.run_mask;
			end else if (cur_valid_q && out_free) begin
				cur_mask_q <= remaining;
				if (remaining == '0) begin
					cur_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_pilot_q <= head_entry.pilot_count;
			cur_data_q  <= head_entry.data_byte;
		end
		if (out_free && cur_valid_q) begin
			duration_q     <= nxt_duration;
			repeat_count_q <= nxt_repeat;
			run_kind_q     <= nxt_kind;
			last_run_q     <= (remaining == '0);
		end
	end

	assign run_valid    = run_valid_q;
	assign duration     = duration_q;
	assign repeat_count = repeat_count_q;
	assign run_kind     = run_kind_q;
	assign last_run     = last_run_q;

endmodule

>>> src/tape_block_pulse_encoder_top.sv
// top level of the tape block pulse encoder
//
// input channel (item_valid / item_stall) takes one block byte per word with
// its first, last and empty marks and its count of valid bits, msb first.
// output channel (run_valid / run_stall) gives pulse runs: duration in
// t-states, repeat count, run kind and a last_run mark on the final run
// of each byte. bytes that cause no run are taken and give nothing.
// a byte gives up to twelve runs: pilot, two sync, eight bit runs, pause.
// the first run of a byte passes the queue, the current-word registers and
// the run register; runs then follow one per cycle while run_stall is low,
// with no gap between bytes. the front end takes a byte per cycle while the
// queue has room, so bytes keep flowing in while earlier runs still wait.
// a stall on the output holds the run register; the queue fills and then
// item_stall rises. configuration goes through cfg_wr_en, cfg_index and
// cfg_data while the block is idle, a rule the block does not enforce. reset
// loads the default timings, empties the queue and drops any pending run.
module tape_block_pulse_encoder_top
	import tbpe_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_of_block,
	input  logic        last_of_block,
	input  logic [3:0]  bit_count,
	input  logic        empty_block,
	output logic        run_valid,
	input  logic        run_stall,
	output logic [27:0] duration,
	output logic [15:0] repeat_count,
	output logic [2:0]  run_kind,
	output logic        last_run
);

	tbpe_cfg_t   cfg;
	logic        queue_push;
	logic        queue_full;
	logic        queue_head_valid;
	logic        queue_pop;
	tbpe_entry_t push_entry;
	tbpe_entry_t head_entry;

	tbpe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tbpe_front u_front (
		.cfg            (cfg),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.data_byte      (data_byte),
		.first_of_block (first_of_block),
		.last_of_block  (last_of_block),
		.bit_count      (bit_count),
		.empty_block    (empty_block),
		.queue_full     (queue_full),
		.push           (queue_push),
		.push_entry     (push_entry)
	);

	tbpe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (queue_push),
		.push_entry (push_entry),
		.full       (queue_full),
		.head_valid (queue_head_valid),
		.head_entry (head_entry),
		.pop        (queue_pop)
	);

	tbpe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head_valid   (queue_head_valid),
		.head_entry   (head_entry),
		.pop          (queue_pop),
		.run_valid    (run_valid),
		.run_stall    (run_stall),
		.duration     (duration),
		.repeat_count (repeat_count),
		.run_kind     (run_kind),
		.last_run     (last_run)
	);

endmodule

>>> src/tbpe_checker.sv
// port-level checks of the tape block pulse encoder and their binding
module tbpe_checker
	import tbpe_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        run_valid,
	input logic        run_stall,
	input logic [27:0] duration,
	input logic [15:0] repeat_count,
	input logic [2:0]  run_kind,
	input logic        last_run
);

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_stall |=> run_valid && $stable(duration) &&
			$stable(repeat_count) && $stable(run_kind) && $stable(last_run))
		else $error("stalled run word changed");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && (run_kind == KIND_SYNC_ONE || run_kind == KIND_SYNC_TWO ||
			run_kind == KIND_PAUSE) |-> repeat_count == 16'd1)
		else $error("sync or pause run not a single pulse");

	a_bit_pair: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && (run_kind == KIND_ZERO_BIT || run_kind == KIND_ONE_BIT)
			|-> repeat_count == 16'd2)
		else $error("bit run not a pulse pair");

	a_pause_last: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_kind == KIND_PAUSE |-> last_run)
		else $error("pause run not marked last");

	a_pilot_count: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_kind == KIND_PILOT |-> repeat_count != 16'd0)
		else $error("pilot run with zero pulses");

endmodule

bind tape_block_pulse_encoder_top tbpe_checker u_tbpe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.run_valid    (run_valid),
	.run_stall    (run_stall),
	.duration     (duration),
	.repeat_count (repeat_count),
	.run_kind     (run_kind),
	.last_run     (last_run)
);
